>>> rtl/core/skq_pkg.sv
// Shared types and constants for the sorted key queue.
package skq_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int KEY_BITS         = 16;
    localparam int IDX_BITS         = 6;
    localparam int STATUS_BITS      = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } op_t;

endpackage

>>> rtl/core/skq_cell.sv
// One slot of the sorted chain: holds a key and payload, shifts with its neighbors.
module skq_cell #(
    parameter int POS          = 0,
    parameter int CAPACITY     = skq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = skq_pkg::PAYLOAD_BITS_DEF,
    localparam int CW          = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  skq_pkg::op_t                  op,
    input  logic [skq_pkg::KEY_BITS-1:0]  new_key,
    input  logic [PAYLOAD_BITS-1:0]       new_payload,
    input  logic [CW-1:0]                 count,
    input  logic [skq_pkg::IDX_BITS-1:0]  idx,
    input  logic                          prev_gt,
    input  logic [skq_pkg::KEY_BITS-1:0]  prev_key,
    input  logic [PAYLOAD_BITS-1:0]       prev_payload,
    input  logic [skq_pkg::KEY_BITS-1:0]  next_key,
    input  logic [PAYLOAD_BITS-1:0]       next_payload,
    output logic [skq_pkg::KEY_BITS-1:0]  key,
    output logic [PAYLOAD_BITS-1:0]       payload,
    output logic                          gt,
    output logic [PAYLOAD_BITS-1:0]       tap
);

    localparam int CMPW = (CW > skq_pkg::IDX_BITS) ? CW : skq_pkg::IDX_BITS;
    localparam logic [CMPW-1:0] POS_V  = CMPW'(POS);
    localparam logic [CMPW-1:0] POS1_V = CMPW'(POS + 1);

    logic [skq_pkg::KEY_BITS-1:0] key_reg;
    logic [skq_pkg::KEY_BITS-1:0] key_next;
    logic [PAYLOAD_BITS-1:0]      payload_reg;
    logic [PAYLOAD_BITS-1:0]      payload_next;
    logic [CMPW-1:0]              cnt_x;
    logic [CMPW-1:0]              idx_x;
    logic                         occupied;
    logic                         at_end;
    logic                         hit;
    logic                         pull_next;

    assign cnt_x     = CMPW'(count);
    assign idx_x     = CMPW'(idx);
    assign occupied  = POS_V < cnt_x;
    assign at_end    = POS_V == cnt_x;
    assign gt        = occupied && (key_reg > new_key);
    assign hit       = op.rem && (POS_V == idx_x);
    // close the gap: every slot from the removed one up to the last but one pulls
    assign pull_next = op.rem && (POS_V >= idx_x) && (POS1_V < cnt_x);

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (op.ins)
        begin
            if (prev_gt)
            begin
                key_next     = prev_key;
                payload_next = prev_payload;
            end
            else if (gt || at_end)
            begin
                key_next     = new_key;
                payload_next = new_payload;
            end
        end
        else if (pull_next)
        begin
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign tap     = hit ? payload_reg : '0;

endmodule

>>> rtl/core/skq_or_tree.sv
// Registered OR-reduction tree that collects the removed payload from the cells.
module skq_or_tree #(
    parameter int LEAVES = skq_pkg::CAPACITY_DEF,
    parameter int WIDTH  = skq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic             clk,
    input  logic             load,
    input  logic [WIDTH-1:0] leaf [LEAVES],
    output logic [WIDTH-1:0] root
);

    localparam int DEPTH = $clog2(LEAVES);
    localparam int SPAN  = 1 << DEPTH;
    localparam int NODES = 2 * SPAN - 1;

    logic [WIDTH-1:0] node_reg [NODES];

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < SPAN - 1; n++)
        begin
            node_reg[n] <= node_reg[2 * n + 1] | node_reg[2 * n + 2];
        end
        for (int j = 0; j < SPAN; j++)
        begin
            if (load && (j < LEAVES))
            begin
                node_reg[SPAN - 1 + j] <= leaf[j];
            end
            else
            begin
                node_reg[SPAN - 1 + j] <= '0;
            end
        end
    end

    assign root = node_reg[0];

endmodule

>>> rtl/core/sorted_key_queue.sv
// Top level of the sorted key queue: cell chain, payload collect tree and control.
//
// Usage: raise start with req_type, key, payload and index while busy is low;
// the beat is taken at that clock edge. An insert places the key after every
// stored key that is less than or equal to it; a remove takes out the entry at
// position index (0 is the smallest key) and the entries behind it move down.
// The table itself is updated in the cycle of acceptance by a row of cells,
// each comparing its key against the broadcast key and taking its neighbor's
// entry when the row shifts.
// The result (status, payload_out, entry_count, is_empty) is shown once the
// removed payload has passed through a registered OR tree of $clog2(CAPACITY)
// levels, marked by done for exactly one cycle, and is taken at the edge that
// ends that cycle; a phase counter, loaded on acceptance, times done.
// busy stays high until the result beat has been taken, so one request is in
// flight at a time.
// The receiver cannot stall; done must be taken when it is shown.
// Reset empties the table at once; no clearing pass is needed.
module sorted_key_queue #(
    parameter int CAPACITY     = skq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = skq_pkg::PAYLOAD_BITS_DEF,
    localparam int CW          = $clog2(CAPACITY + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             req_type,
    input  logic [skq_pkg::KEY_BITS-1:0]     key,
    input  logic [PAYLOAD_BITS-1:0]          payload,
    input  logic [skq_pkg::IDX_BITS-1:0]     index,
    output logic                             done,
    output logic [skq_pkg::STATUS_BITS-1:0]  status,
    output logic [PAYLOAD_BITS-1:0]          payload_out,
    output logic [CW-1:0]                    entry_count,
    output logic                             is_empty
);

    localparam int TREE_DEPTH = $clog2(CAPACITY);
    localparam int PW         = $clog2(TREE_DEPTH + 2);
    localparam int CMPW       = (CW > skq_pkg::IDX_BITS) ? CW : skq_pkg::IDX_BITS;
    localparam logic [CW-1:0] CAP_V   = CW'(CAPACITY);
    localparam logic [PW-1:0] PHASE_V = PW'(TREE_DEPTH + 1);
    localparam logic [PW-1:0] PHASE_1 = PW'(1);

    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [PW-1:0]                    phase_reg;
    logic [PW-1:0]                    phase_next;
    logic [skq_pkg::STATUS_BITS-1:0]  status_reg;
    logic [skq_pkg::STATUS_BITS-1:0]  status_next;

    logic          accept;
    logic          full;
    logic          found;
    skq_pkg::op_t  op;

    logic [skq_pkg::KEY_BITS-1:0]  key_w [CAPACITY];
    logic [PAYLOAD_BITS-1:0]       pay_w [CAPACITY];
    logic                          gt_w  [CAPACITY];
    logic [PAYLOAD_BITS-1:0]       tap_w [CAPACITY];

    assign busy   = phase_reg != '0;
    assign accept = start && !busy;
    assign full   = count_reg == CAP_V;
    assign found  = CMPW'(index) < CMPW'(count_reg);
    assign op.ins = accept && (req_type == skq_pkg::REQ_INSERT) && !full;
    assign op.rem = accept && (req_type == skq_pkg::REQ_REMOVE) && found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                          prev_gt;
        logic [skq_pkg::KEY_BITS-1:0]  prev_key;
        logic [PAYLOAD_BITS-1:0]       prev_pay;
        logic [skq_pkg::KEY_BITS-1:0]  next_key;
        logic [PAYLOAD_BITS-1:0]       next_pay;

        if (i == 0)
        begin : g_head
            assign prev_gt  = 1'b0;
            assign prev_key = '0;
            assign prev_pay = '0;
        end
        else
        begin : g_body
            assign prev_gt  = gt_w[i-1];
            assign prev_key = key_w[i-1];
            assign prev_pay = pay_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_key = '0;
            assign next_pay = '0;
        end
        else
        begin : g_mid
            assign next_key = key_w[i+1];
            assign next_pay = pay_w[i+1];
        end

        skq_cell #(
            .POS          (i),
            .CAPACITY     (CAPACITY),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk          (clk),
            .op           (op),
            .new_key      (key),
            .new_payload  (payload),
            .count        (count_reg),
            .idx          (index),
            .prev_gt      (prev_gt),
            .prev_key     (prev_key),
            .prev_payload (prev_pay),
            .next_key     (next_key),
            .next_payload (next_pay),
            .key          (key_w[i]),
            .payload      (pay_w[i]),
            .gt           (gt_w[i]),
            .tap          (tap_w[i])
        );
    end

    skq_or_tree #(
        .LEAVES (CAPACITY),
        .WIDTH  (PAYLOAD_BITS)
    ) u_tree (
        .clk  (clk),
        .load (accept),
        .leaf (tap_w),
        .root (payload_out)
    );

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        phase_next  = phase_reg;
        if (accept)
        begin
            phase_next = PHASE_V;
            case (req_type)
                skq_pkg::REQ_INSERT:
                begin
                    if (full)
                    begin
                        status_next = skq_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = skq_pkg::ST_DONE;
                        count_next  = count_reg + CW'(1);
                    end
                end
                skq_pkg::REQ_REMOVE:
                begin
                    if (found)
                    begin
                        status_next = skq_pkg::ST_DONE;
                        count_next  = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = skq_pkg::ST_NOTFOUND;
                    end
                end
                default:
                begin
                    status_next = skq_pkg::ST_DONE;
                end
            endcase
        end
        else if (busy)
        begin
            // advance toward the result beat
            phase_next = phase_reg - PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            phase_reg  <= '0;
            status_reg <= skq_pkg::ST_DONE;
        end
        else
        begin
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
        end
    end

    assign done        = phase_reg == PHASE_1;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign is_empty    = count_reg == '0;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_V)
        else $error("entry count exceeds capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == skq_pkg::ST_FULL) |-> entry_count == CAP_V)
        else $error("full status reported while table not full");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == skq_pkg::ST_NOTFOUND) |-> payload_out == '0)
        else $error("failed remove returned a payload");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        op.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance the entry count");

endmodule
